>>> src/lnp_pkg.sv
// lnp_pkg: shared constants, register indexes and controller/datapath
// command and status types for the LIF neuron pool.
// No dependencies; compiled first.
`default_nettype none

package lnp_pkg;

   // Neuron pool
   localparam int NEURONS  = 64;
   localparam int NEURON_AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
   localparam int CNT_W    = $clog2(NEURONS + 1);

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] REG_DECAY_FACTOR   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INPUT_GAIN     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RESET_LEVEL    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_REFRACTORY     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_NEURONS_IN_USE = 3'd4;

   localparam logic [15:0]        DECAY_RST      = 16'd65434;
   localparam logic [15:0]        GAIN_RST       = 16'd2048;
   localparam logic signed [23:0] RESET_LVL_RST  = -24'sd32768;
   localparam logic [3:0]         REFRACT_RST    = 4'd1;
   localparam logic [6:0]         NIU_RST        = 7'd64;

   // Membrane format, signed Q8.16
   localparam logic signed [23:0] MEM_MAX   = 24'sh7FFFFF;
   localparam logic signed [23:0] MEM_MIN   = -24'sh800000;
   localparam logic signed [23:0] THRESHOLD = 24'sd65536;

   typedef struct packed {
      logic                 load;    // item accepted, capture payload
      logic                 mult;    // sample * gain
      logic                 scale;   // round to Q8.16 drive
      logic                 issue;   // start one neuron update
      logic [NEURON_AW-1:0] addr;    // neuron being issued
      logic                 finish;  // load result register
   } lnp_cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;      // neurons to update per item
      logic             pipe_busy;  // neuron updates still in flight
      logic             out_free;   // result register empty
   } lnp_status_type;

endpackage

`default_nettype wire

>>> src/lnp_ifs.sv
// lnp_req_if / lnp_rsp_if: valid/ready channels of the LIF neuron pool.
// Standalone; no package dependency.
`default_nettype none

interface lnp_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample;
   logic               block_end;

   modport source (output valid, output sample, output block_end, input ready);
   modport sink   (input valid, input sample, input block_end, output ready);
endinterface

interface lnp_rsp_if;
   logic        valid;
   logic        ready;
   logic [6:0]  spike_count;
   logic        block_done;
   logic [15:0] block_total;

   modport source (output valid, output spike_count, output block_done,
                   output block_total, input ready);
   modport sink   (input valid, input spike_count, input block_done,
                   input block_total, output ready);
endinterface

`default_nettype wire

>>> src/lnp_datapath.sv
// lnp_datapath: configuration registers, neuron state memory, three-stage
// neuron update pipeline, spike counting and the result register.
// Depends on lnp_pkg.
`default_nettype none

module lnp_datapath import lnp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   input  logic signed [15:0]    req_sample,
   input  logic                  req_block_end,
   input  lnp_cmd_type           cmd,
   output lnp_status_type        status,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [6:0]            rsp_spike_count,
   output logic                  rsp_block_done,
   output logic [15:0]           rsp_block_total
);

   // configuration
   logic [15:0]        decay_ff;
   logic [15:0]        gain_ff;
   logic signed [23:0] reset_lvl_ff;
   logic [3:0]         refract_ff;
   logic [6:0]         niu_ff;

   // item
   logic signed [15:0] sample_ff;
   logic               block_end_ff;
   logic signed [32:0] gain_prod_ff;
   logic signed [32:0] gain_round;
   logic signed [37:0] bias_ff;

   // neuron memory: {refractory_left, membrane}
   logic [27:0]          nmem [NEURONS];
   logic [NEURONS-1:0]   entry_vld_ff;

   // stage 1
   logic                 s1_valid_ff;
   logic [NEURON_AW-1:0] s1_addr_ff;
   logic                 s1_hit_ff;
   logic [27:0]          rd_word_ff;
   logic signed [23:0]   s1_mem;
   logic [3:0]           s1_ref;

   // stage 2
   logic                 s2_valid_ff;
   logic [NEURON_AW-1:0] s2_addr_ff;
   logic signed [23:0]   s2_mem_ff;
   logic [3:0]           s2_ref_ff;
   logic signed [40:0]   s2_prod_ff;
   logic signed [41:0]   s2_sum;
   logic signed [25:0]   s2_v;
   logic signed [23:0]   s2_sat;
   logic                 s2_fire;
   logic [27:0]          wr_word;

   // counting and result
   logic [6:0]   spike_cnt_ff;
   logic [15:0]  block_sum_ff;
   logic [16:0]  sum_wide;
   logic [15:0]  sum_in;
   logic         rsp_valid_ff;
   logic [6:0]   rsp_count_ff;
   logic         rsp_done_ff;
   logic [15:0]  rsp_total_ff;
   logic [CNT_W-1:0] count;

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff     <= DECAY_RST;
         gain_ff      <= GAIN_RST;
         reset_lvl_ff <= RESET_LVL_RST;
         refract_ff   <= REFRACT_RST;
         niu_ff       <= NIU_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_DECAY_FACTOR:   decay_ff     <= csr_wr_data[15:0];
            REG_INPUT_GAIN:     gain_ff      <= csr_wr_data[15:0];
            REG_RESET_LEVEL:    reset_lvl_ff <= $signed(csr_wr_data[23:0]);
            REG_REFRACTORY:     refract_ff   <= csr_wr_data[3:0];
            REG_NEURONS_IN_USE: niu_ff       <= csr_wr_data[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (32'(niu_ff) > NEURONS) begin
         count = CNT_W'(NEURONS);
      end else begin
         count = CNT_W'(niu_ff);
      end
   end

   // drive = round(sample*gain / 2^11); bias folds in the leak rounding term
   assign gain_round = gain_prod_ff + 33'sd1024;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff    <= req_sample;
         block_end_ff <= req_block_end;
      end
      if (cmd.mult) begin
         gain_prod_ff <= sample_ff * $signed({1'b0, gain_ff});
      end
      if (cmd.scale) begin
         bias_ff <= $signed({gain_round[32:11], 16'h8000});
      end
   end

   // stage 0 -> 1: memory read
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_word_ff <= nmem[cmd.addr];
      end
      s1_addr_ff <= cmd.addr;
      s1_hit_ff  <= entry_vld_ff[cmd.addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // never-written entries read as the reset state
   assign s1_mem = s1_hit_ff ? $signed(rd_word_ff[23:0]) : 24'sd0;
   assign s1_ref = s1_hit_ff ? rd_word_ff[27:24] : 4'd0;

   // stage 1 -> 2: leak multiply
   always_ff @(posedge clock) begin
      s2_addr_ff <= s1_addr_ff;
      s2_mem_ff  <= s1_mem;
      s2_ref_ff  <= s1_ref;
      s2_prod_ff <= s1_mem * $signed({1'b0, decay_ff});
   end

   // stage 2: refractory countdown, or integrate, saturate, threshold; write back
   always_comb begin
      s2_sum = 42'(s2_prod_ff) + 42'(bias_ff);
      s2_v   = s2_sum[41:16];
      if (s2_v > 26'(MEM_MAX)) begin
         s2_sat = MEM_MAX;
      end else if (s2_v < 26'(MEM_MIN)) begin
         s2_sat = MEM_MIN;
      end else begin
         s2_sat = s2_v[23:0];
      end
      s2_fire = 1'b0;
      if (s2_ref_ff != 4'd0) begin
         wr_word = {s2_ref_ff - 4'd1, s2_mem_ff};
      end else if (s2_sat >= THRESHOLD) begin
         s2_fire = 1'b1;
         wr_word = {refract_ff, reset_lvl_ff};
      end else begin
         wr_word = {4'd0, s2_sat};
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         nmem[s2_addr_ff] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_vld_ff <= '0;
      end else if (s2_valid_ff) begin
         entry_vld_ff[s2_addr_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spike_cnt_ff <= 7'd0;
      end else if (cmd.load) begin
         spike_cnt_ff <= 7'd0;
      end else if (s2_valid_ff && s2_fire) begin
         spike_cnt_ff <= spike_cnt_ff + 7'd1;
      end
   end

   assign sum_wide = {1'b0, block_sum_ff} + 17'(spike_cnt_ff);
   assign sum_in   = sum_wide[16] ? 16'hFFFF : sum_wide[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         block_sum_ff <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            block_sum_ff <= block_end_ff ? 16'd0 : sum_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_count_ff <= spike_cnt_ff;
         rsp_done_ff  <= block_end_ff;
         rsp_total_ff <= block_end_ff ? sum_in : 16'd0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_spike_count = rsp_count_ff;
   assign rsp_block_done  = rsp_done_ff;
   assign rsp_block_total = rsp_total_ff;

   assign status.count     = count;
   assign status.pipe_busy = s1_valid_ff | s2_valid_ff;
   assign status.out_free  = ~rsp_valid_ff;

`ifndef SYNTH
   a_finish_clean: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !s1_valid_ff && !s2_valid_ff && !rsp_valid_ff)
      else $error("result loaded while pipeline busy or result pending");

   a_stage_order: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> $past(s1_valid_ff))
      else $error("stage 2 valid without stage 1");

   a_total_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_done_ff |-> rsp_total_ff == 16'd0)
      else $error("block total nonzero outside block end");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> 32'(spike_cnt_ff) <= 32'(count))
      else $error("more spikes than neurons in use");
`endif

endmodule

`default_nettype wire

>>> src/lnp_ctrl.sv
// lnp_ctrl: item sequencer for the LIF neuron pool; accepts an item,
// steps the drive setup, issues one neuron per cycle and hands off the result.
// Depends on lnp_pkg.
`default_nettype none

module lnp_ctrl import lnp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  lnp_status_type status,
   output lnp_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MULT  = 3'd1;
   localparam logic [2:0] ST_SCALE = 3'd2;
   localparam logic [2:0] ST_RUN   = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;

   logic [2:0]       state_ff;
   logic [2:0]       state_in;
   logic [CNT_W-1:0] idx_ff;
   logic [CNT_W-1:0] idx_in;
   logic [CNT_W-1:0] idx_next;

   assign idx_next = idx_ff + CNT_W'(1);

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      cmd.addr   = idx_ff[NEURON_AW-1:0];
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            idx_in    = '0;
            state_in  = (status.count == '0) ? ST_DRAIN : ST_RUN;
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            idx_in    = idx_next;
            if (idx_next == status.count) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // wait for the last write-back and a free result register
            if (!status.pipe_busy && status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

`default_nettype wire

>>> src/lif_neuron_pool.sv
// lif_neuron_pool: top level of a pool of leaky integrate-and-fire neurons.
// Depends on lnp_pkg, lnp_ifs (lnp_req_if, lnp_rsp_if), lnp_ctrl, lnp_datapath.
//
// Usage:
//   req_chan carries one audio sample (signed Q1.15) and a block_end flag per
//   item; rsp_chan returns exactly one result per item: spike_count, and on a
//   block end block_done = 1 with the saturating block spike total.
//   csr_* writes a configuration register (decay, gain, reset level,
//   refractory samples, neurons in use); write only while no item is open.
//   One item is in work at a time. After acceptance the block forms the
//   drive (multiply, then scale), then updates one neuron per cycle
//   through a three-stage read / multiply / write-back pipeline on a
//   neuron state memory with separate read and write ports. Once the last
//   write-back is done and the result register is free, the result is
//   registered and the block returns to idle to take the next item.
//   The result sits in an output register, so a stalled receiver only holds
//   back the hand-off at the end of the following item.
//   Reset (synchronous) restores register defaults and clears neuron state at
//   once through per-entry valid bits; no clearing pass is needed.
`default_nettype none

module lif_neuron_pool import lnp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   lnp_req_if.sink               req_chan,
   lnp_rsp_if.source             rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   lnp_cmd_type    cmd;
   lnp_status_type status;
   logic           req_ready;
   logic           rsp_valid;
   logic [6:0]     rsp_spike_count;
   logic           rsp_block_done;
   logic [15:0]    rsp_block_total;

   lnp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lnp_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .req_sample      (req_chan.sample),
      .req_block_end   (req_chan.block_end),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_spike_count (rsp_spike_count),
      .rsp_block_done  (rsp_block_done),
      .rsp_block_total (rsp_block_total)
   );

   assign req_chan.ready       = req_ready;
   assign rsp_chan.valid       = rsp_valid;
   assign rsp_chan.spike_count = rsp_spike_count;
   assign rsp_chan.block_done  = rsp_block_done;
   assign rsp_chan.block_total = rsp_block_total;

endmodule

`default_nettype wire
